// ===== sv/gql_pkg.sv =====
// ----------------------------------------------------------------------------
// gql_pkg
// shared types, constants and helpers of the glyph quad layout engine
// ----------------------------------------------------------------------------
package gql_pkg;

  localparam int unsigned GlyphEntriesDefault = 256;
  localparam int unsigned InDataW  = 104;
  localparam int unsigned OutDataW = 152;

  localparam logic [7:0] CodeTab     = 8'd9;
  localparam logic [7:0] CodeNewline = 8'd10;
  localparam logic [7:0] CodeSpace   = 8'd32;
  localparam logic [7:0] CodeQmark   = 8'd63;

  typedef enum logic [2:0] {
    CfgOriginX    = 3'd0,
    CfgOriginY    = 3'd1,
    CfgScale      = 3'd2,
    CfgLineHeight = 3'd3,
    CfgFontSize   = 3'd4,
    CfgClipEnable = 3'd5,
    CfgClipOrigin = 3'd6,
    CfgClipSize   = 3'd7
  } cfg_reg_e;

  // one glyph table entry, atlas_x in the lowest bits
  typedef struct packed {
    logic [15:0]        advance;
    logic signed [15:0] offset_y;
    logic signed [15:0] offset_x;
    logic [11:0]        box_h;
    logic [11:0]        box_w;
    logic [11:0]        atlas_y;
    logic [11:0]        atlas_x;
  } glyph_t;

  // lookup status returned with the read data
  typedef struct packed {
    logic ok_a;
    logic ok_q;
  } lkp_t;

  function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
    logic signed [15:0] r;
    if (v > 24'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -24'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/gql_glyph_table.sv =====
// ----------------------------------------------------------------------------
// gql_glyph_table
// glyph table memory with one write port, a read port for the requested code
// and a read port for the fallback glyph, plus the entry valid bits
// ----------------------------------------------------------------------------
module gql_glyph_table #(
  parameter int unsigned GLYPH_ENTRIES = gql_pkg::GlyphEntriesDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  logic [7:0]      wr_code_i,
  input  gql_pkg::glyph_t wr_data_i,
  input  logic            rd_en_i,
  input  logic [7:0]      rd_code_i,
  output gql_pkg::glyph_t rd_a_o,
  output gql_pkg::glyph_t rd_q_o,
  output gql_pkg::lkp_t   lkp_o
);
  import gql_pkg::*;

  localparam int unsigned     AddrW = $clog2(GLYPH_ENTRIES);
  localparam logic [8:0]      Limit = 9'(GLYPH_ENTRIES);
  localparam logic [AddrW-1:0] QAddr = AddrW'(CodeQmark);

  glyph_t                   mem_q [GLYPH_ENTRIES];
  logic [GLYPH_ENTRIES-1:0] valid_q;
  glyph_t                   rd_a_q, rd_q_q;
  lkp_t                     lkp_q;
  logic                     wr_hit, rd_in;
  logic [AddrW-1:0]         wr_addr, rd_addr;

  assign wr_hit  = wr_en_i && ({1'b0, wr_code_i} < Limit);
  assign rd_in   = {1'b0, rd_code_i} < Limit;
  assign wr_addr = wr_code_i[AddrW-1:0];
  assign rd_addr = rd_code_i[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      mem_q[wr_addr] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_a_q <= mem_q[rd_addr];
      rd_q_q <= mem_q[QAddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      lkp_q   <= '0;
    end else begin
      if (wr_hit) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (rd_en_i) begin
        lkp_q.ok_a <= rd_in && valid_q[rd_addr];
        lkp_q.ok_q <= valid_q[QAddr];
      end
    end
  end

  assign rd_a_o = rd_a_q;
  assign rd_q_o = rd_q_q;
  assign lkp_o  = lkp_q;

endmodule

// ===== sv/glyph_quad_layout_top.sv =====
// ----------------------------------------------------------------------------
// glyph_quad_layout_top
// bitmap font text layout: glyph table, pen tracking, quad and metrics output
// ----------------------------------------------------------------------------
// Usage: the slave stream carries write items (tuser bit 0 low) that load one
// glyph table entry and character items (tuser bit 0 high) that move the pen.
// tuser bit 1 starts a new text, tlast closes it and asks for a metrics result.
// Registers are written on the cfg channel, which is always ready; write them
// only while no transaction is in flight.
// Pipeline: a character is read from the table at its accepting edge, then
// passes the multiply, the pen update and the output register on its way to the
// master stream. One item is accepted every cycle while no stall holds
// s_axis_tready_o low; an item with both a quad and a metrics result holds
// s_axis_tready_o low while the single output register takes the two results in turn.
// Write items take effect at once and produce nothing.
// Reset clears every glyph valid bit, the pen, the metrics and the pipeline;
// registers take their defaults. No clearing pass is needed.
// A stalled master holds its result; once stage 3 holds a result for it, the
// pipeline freezes behind it and s_axis_tready_o drops until the held result is taken.
// ----------------------------------------------------------------------------
module glyph_quad_layout_top #(
  parameter int unsigned GLYPH_ENTRIES = gql_pkg::GlyphEntriesDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [2:0]                   cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // code, atlas_x, atlas_y, box_w, box_h, offset_x, offset_y, advance
  input  logic [gql_pkg::InDataW-1:0]  s_axis_tdata_i,
  // func, first_of_text
  input  logic [1:0]                   s_axis_tuser_i,
  input  logic                         s_axis_tlast_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // left, top, right, bottom, tex_left, tex_top, tex_right, tex_bottom,
  // line_count, text_width, zero pad
  output logic [gql_pkg::OutDataW-1:0] m_axis_tdata_o,
  // kind
  output logic                         m_axis_tuser_o,
  output logic                         m_axis_tlast_o
);
  import gql_pkg::*;

  typedef struct packed {
    logic nl;
    logic tab;
    logic first;
    logic last;
  } s1_t;

  typedef struct packed {
    logic               nl;
    logic               tab;
    logic               glyph;
    logic               first;
    logic               last;
    logic signed [20:0] sox;
    logic signed [20:0] soy;
    logic [21:0]        d;
    logic [19:0]        sw;
    logic [19:0]        sh;
    logic [12:0]        tex_l;
    logic [12:0]        tex_t;
    logic [12:0]        tex_r;
    logic [12:0]        tex_b;
  } s2_t;

  typedef struct packed {
    logic               draw;
    logic               metrics;
    logic signed [15:0] l;
    logic signed [15:0] t;
    logic [19:0]        sw;
    logic [19:0]        sh;
    logic [12:0]        tex_l;
    logic [12:0]        tex_t;
    logic [12:0]        tex_r;
    logic [12:0]        tex_b;
    logic [15:0]        lines;
    logic [15:0]        lw;
    logic [15:0]        wl;
  } s3_t;

  // configuration registers
  logic signed [15:0] origin_x_q, origin_y_q;
  logic [15:0]        scale_q, line_height_q, font_size_q;
  logic               clip_enable_q;
  logic [31:0]        clip_origin_q, clip_size_q;

  // layout state
  logic signed [15:0] pen_x_q, pen_x_d, pen_y_q, pen_y_d;
  logic [15:0]        lw_q, lw_d, wl_q, wl_d, lines_q, lines_d;

  // pipeline
  logic   pipe_en, accept, is_char;
  logic   s1_valid_q, s2_valid_q, s3_valid_q, quad_sent_q, quad_sent_d;
  s1_t    s1_q;
  s2_t    s2_q, s2_d;
  s3_t    s3_q, s3_d;
  logic [7:0] code, rd_code;
  glyph_t rd_a, rd_q, g;
  lkp_t   lkp;

  // output register
  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  logic                out_kind_q, out_kind_d, out_last_q, out_last_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q    <= '0;
      origin_y_q    <= '0;
      scale_q       <= 16'd4096;
      line_height_q <= 16'd896;
      font_size_q   <= 16'd768;
      clip_enable_q <= 1'b0;
      clip_origin_q <= '0;
      clip_size_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgOriginX:    origin_x_q    <= cfg_data_i[15:0];
        CfgOriginY:    origin_y_q    <= cfg_data_i[15:0];
        CfgScale:      scale_q       <= cfg_data_i[15:0];
        CfgLineHeight: line_height_q <= cfg_data_i[15:0];
        CfgFontSize:   font_size_q   <= cfg_data_i[15:0];
        CfgClipEnable: clip_enable_q <= cfg_data_i[0];
        CfgClipOrigin: clip_origin_q <= cfg_data_i;
        CfgClipSize:   clip_size_q   <= cfg_data_i;
      endcase
    end
  end

  // accept and table access
  assign s_axis_tready_o = pipe_en;
  assign accept  = s_axis_tvalid_i && pipe_en;
  assign is_char = s_axis_tuser_i[0];
  assign code    = s_axis_tdata_i[7:0];
  assign rd_code = (code == CodeTab) ? CodeSpace : code;

  gql_glyph_table #(
    .GLYPH_ENTRIES(GLYPH_ENTRIES)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (accept && !is_char),
    .wr_code_i (code),
    .wr_data_i (glyph_t'(s_axis_tdata_i[InDataW-1:8])),
    .rd_en_i   (accept && is_char),
    .rd_code_i (rd_code),
    .rd_a_o    (rd_a),
    .rd_q_o    (rd_q),
    .lkp_o     (lkp)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q.nl    <= code == CodeNewline;
      s1_q.tab   <= code == CodeTab;
      s1_q.first <= s_axis_tuser_i[1];
      s1_q.last  <= s_axis_tlast_i;
    end
  end

  // scaling multiplies
  always_comb begin
    logic        found;
    logic [17:0] op;
    logic signed [32:0] mul_ox, mul_oy, rnd_ox, rnd_oy;
    logic [33:0] mul_d, rnd_d;
    logic [27:0] mul_w, mul_h, rnd_w, rnd_h;
    found = lkp.ok_a || lkp.ok_q;
    g     = lkp.ok_a ? rd_a : rd_q;
    if (s1_q.nl) begin
      op = {2'b00, line_height_q};
    end else if (s1_q.tab) begin
      op = found ? {g.advance, 2'b00} : {1'b0, font_size_q, 1'b0};
    end else begin
      op = {2'b00, g.advance};
    end
    mul_ox = $signed(g.offset_x) * $signed({1'b0, scale_q});
    mul_oy = $signed(g.offset_y) * $signed({1'b0, scale_q});
    rnd_ox = mul_ox + 33'sd2048;
    rnd_oy = mul_oy + 33'sd2048;
    mul_d  = 34'(op) * 34'(scale_q);
    rnd_d  = mul_d + 34'd2048;
    mul_w  = 28'(g.box_w) * 28'(scale_q);
    mul_h  = 28'(g.box_h) * 28'(scale_q);
    rnd_w  = mul_w + 28'd128;
    rnd_h  = mul_h + 28'd128;

    s2_d.nl    = s1_q.nl;
    s2_d.tab   = s1_q.tab;
    s2_d.glyph = !s1_q.nl && !s1_q.tab && found;
    s2_d.first = s1_q.first;
    s2_d.last  = s1_q.last;
    s2_d.sox   = rnd_ox[32:12];
    s2_d.soy   = rnd_oy[32:12];
    s2_d.d     = rnd_d[33:12];
    s2_d.sw    = rnd_w[27:8];
    s2_d.sh    = rnd_h[27:8];
    s2_d.tex_l = {1'b0, g.atlas_x};
    s2_d.tex_t = {1'b0, g.atlas_y};
    s2_d.tex_r = {1'b0, g.atlas_x} + {1'b0, g.box_w};
    s2_d.tex_b = {1'b0, g.atlas_y} + {1'b0, g.box_h};
  end

  // pen and metrics update
  always_comb begin
    logic signed [15:0] pxb, pyb;
    logic [15:0]        lwb, wlb, lsb;
    logic signed [23:0] px_ext, py_ext, d_ext, sum_x, sum_y, sum_l, sum_t;
    logic [22:0]        lw_sum;
    logic [15:0]        lw_adv;
    pxb    = s2_q.first ? origin_x_q : pen_x_q;
    pyb    = s2_q.first ? origin_y_q : pen_y_q;
    lwb    = s2_q.first ? 16'd0 : lw_q;
    wlb    = s2_q.first ? 16'd0 : wl_q;
    lsb    = s2_q.first ? 16'd1 : lines_q;
    px_ext = $signed({{8{pxb[15]}}, pxb});
    py_ext = $signed({{8{pyb[15]}}, pyb});
    d_ext  = $signed({2'b00, s2_q.d});
    sum_x  = px_ext + d_ext;
    sum_y  = py_ext + d_ext;
    sum_l  = px_ext + $signed({{3{s2_q.sox[20]}}, s2_q.sox});
    sum_t  = py_ext + $signed({{3{s2_q.soy[20]}}, s2_q.soy});
    lw_sum = {7'd0, lwb} + {1'b0, s2_q.d};
    lw_adv = (|lw_sum[22:16]) ? 16'hFFFF : lw_sum[15:0];

    pen_x_d = pxb;
    pen_y_d = pyb;
    lw_d    = lwb;
    wl_d    = wlb;
    lines_d = lsb;
    if (s2_q.nl) begin
      wl_d    = (lwb > wlb) ? lwb : wlb;
      lw_d    = '0;
      lines_d = (lsb == 16'hFFFF) ? lsb : lsb + 16'd1;
      pen_x_d = origin_x_q;
      pen_y_d = sat16(sum_y);
    end else if (s2_q.tab || s2_q.glyph) begin
      pen_x_d = sat16(sum_x);
      lw_d    = lw_adv;
    end

    s3_d.draw    = s2_q.glyph && (scale_q != 16'd0);
    s3_d.metrics = s2_q.last;
    s3_d.l       = sat16(sum_l);
    s3_d.t       = sat16(sum_t);
    s3_d.sw      = s2_q.sw;
    s3_d.sh      = s2_q.sh;
    s3_d.tex_l   = s2_q.tex_l;
    s3_d.tex_t   = s2_q.tex_t;
    s3_d.tex_r   = s2_q.tex_r;
    s3_d.tex_b   = s2_q.tex_b;
    s3_d.lines   = lines_d;
    s3_d.lw      = lw_d;
    s3_d.wl      = wl_d;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s2_q <= s2_d;
      s3_q <= s3_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      quad_sent_q <= 1'b0;
      pen_x_q     <= '0;
      pen_y_q     <= '0;
      lw_q        <= '0;
      wl_q        <= '0;
      lines_q     <= 16'd1;
    end else begin
      quad_sent_q <= quad_sent_d;
      if (pipe_en) begin
        s1_valid_q <= accept && is_char;
        s2_valid_q <= s1_valid_q;
        s3_valid_q <= s2_valid_q;
        if (s2_valid_q) begin
          pen_x_q <= pen_x_d;
          pen_y_q <= pen_y_d;
          lw_q    <= lw_d;
          wl_q    <= wl_d;
          lines_q <= lines_d;
        end
      end
    end
  end

  // clip test and result hand-off
  logic signed [15:0] q_r, q_b, cx, cy;
  logic signed [17:0] cx_end, cy_end;
  logic               clip_ok, vis, quad_pend, met_pend, out_free, push;
  logic [15:0]        text_w;

  always_comb begin
    q_r     = sat16($signed({{8{s3_q.l[15]}}, s3_q.l}) + $signed({4'd0, s3_q.sw}));
    q_b     = sat16($signed({{8{s3_q.t[15]}}, s3_q.t}) + $signed({4'd0, s3_q.sh}));
    cx      = $signed(clip_origin_q[31:16]);
    cy      = $signed(clip_origin_q[15:0]);
    cx_end  = $signed({{2{cx[15]}}, cx}) + $signed({2'b00, clip_size_q[31:16]});
    cy_end  = $signed({{2{cy[15]}}, cy}) + $signed({2'b00, clip_size_q[15:0]});
    clip_ok = (q_r >= cx) && ($signed({{2{s3_q.l[15]}}, s3_q.l}) <= cx_end) &&
              (q_b >= cy) && ($signed({{2{s3_q.t[15]}}, s3_q.t}) <= cy_end);
    vis     = s3_q.draw && (!clip_enable_q || clip_ok);
    text_w  = (s3_q.lw > s3_q.wl) ? s3_q.lw : s3_q.wl;
  end

  assign quad_pend = s3_valid_q && vis && !quad_sent_q;
  assign met_pend  = s3_valid_q && s3_q.metrics;
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign push      = out_free && (quad_pend || met_pend);
  assign pipe_en   = !(quad_pend || met_pend) || (out_free && !(quad_pend && met_pend));

  always_comb begin
    quad_sent_d = quad_sent_q;
    if (pipe_en) begin
      quad_sent_d = 1'b0;
    end else if (push && quad_pend) begin
      quad_sent_d = 1'b1;
    end

    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;
    out_kind_d  = out_kind_q;
    out_last_d  = out_last_q;
    if (push) begin
      out_valid_d = 1'b1;
      if (quad_pend) begin
        out_kind_d = 1'b0;
        out_last_d = !met_pend;
        out_data_d = {4'd0, 16'd0, 16'd0, s3_q.tex_b, s3_q.tex_r, s3_q.tex_t, s3_q.tex_l,
                      q_b, q_r, s3_q.t, s3_q.l};
      end else begin
        out_kind_d = 1'b1;
        out_last_d = 1'b1;
        out_data_d = {4'd0, text_w, s3_q.lines, 116'd0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_kind_q <= out_kind_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

  // assertions
  a_lines_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lines_q != 16'd0)
    else $error("line count reached zero");

  a_quad_sent_needs_metrics: assert property (@(posedge clk_i) disable iff (!rst_ni)
    quad_sent_q |-> (s3_valid_q && s3_q.metrics))
    else $error("quad marked sent without a pending metrics result");

  a_stall_holds_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!pipe_en) |=> (s3_valid_q &&
                    $stable({s3_q.draw, s3_q.metrics, s3_q.lines, s3_q.lw, s3_q.wl})))
    else $error("output stage changed during a stall");

endmodule
